>>> design/mvn_pkg.sv
`timescale 1ns / 1ps
package mvn_pkg;

	// Sizes
	localparam int VERTEX_COUNT = 1024;
	localparam int IDX_W        = $clog2(VERTEX_COUNT);
	localparam int COORD_WIDTH  = 16;
	localparam int MAX_FACES    = 64;
	localparam int CNT_W        = $clog2(MAX_FACES + 1);
	localparam int SUM_W        = 23;
	localparam int NRM_W        = 16;

	// Item kinds
	localparam logic [1:0] MODE_POS  = 2'd0;
	localparam logic [1:0] MODE_TRI  = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_NOP  = 2'd3;

	localparam logic KIND_FACE   = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef struct packed {
		logic [1:0]                    mode;
		logic                          winding;
		logic [IDX_W-1:0]              index_a;
		logic [IDX_W-1:0]              index_b;
		logic [IDX_W-1:0]              index_c;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
	} req_t;

	typedef struct packed {
		logic                    kind;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic [CNT_W-1:0]        face_count;
		logic                    overflow;
	} rsp_t;

	// One accumulator entry per vertex
	typedef struct packed {
		logic                    ovf;
		logic [CNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0] sz;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] sx;
	} acc_t;

endpackage

>>> design/mvn_ram.sv
`timescale 1ns / 1ps
module mvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/mesh_vertex_normal_unit_core.sv
`timescale 1ns / 1ps
// Position write: the unit stays idle. Triangle and read-out include the stages below,
// all skipped for a degenerate triangle or zero sum; the next beat is taken once the result is loaded.
// Stages: the one-bit-a-cycle normalizing shift (0 to 29 places), the bit-serial square root (31
// steps) and three radix-2 dividers run as lanes (16 steps); one item in flight at a time.
// Reset (arst_n low, async) clears control; afterwards a clearing pass zeroes the accumulator
// memory, one entry a cycle, with req_stall held high.
module mesh_vertex_normal_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mvn_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mvn_pkg::rsp_t rsp
);

	localparam int IW   = mvn_pkg::IDX_W;
	localparam int PW   = mvn_pkg::COORD_WIDTH;
	localparam int EW   = PW + 1;
	localparam int XW   = 2 * EW;
	localparam int CW   = XW + 2;
	localparam int SW   = mvn_pkg::SUM_W;
	localparam int NW   = mvn_pkg::NRM_W;
	localparam int KW   = mvn_pkg::CNT_W;
	localparam int AW   = $bits(mvn_pkg::acc_t);
	localparam int HI_B = 30;
	localparam int LO_B = 29;
	localparam int QB   = 15;
	localparam int DW   = HI_B + 14 + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PRD, S_CROSS, S_LOAD, S_ARD, S_NORM,
		S_SQ, S_SQRT, S_DIV, S_CRD, S_CUPD, S_OUT
	} state_t;

	state_t                 state_q;
	logic [4:0]             step_q;
	logic [IW-1:0]          clr_q;
	mvn_pkg::req_t          req_q;
	logic signed [PW-1:0]   pos_q [3][3];
	logic signed [XW-1:0]   p_q;
	logic signed [CW-1:0]   c_q [3];
	logic [CW-1:0]          m_q [3];
	logic                   ng_q [3];
	logic [2*HI_B-1:0]      sq_p_q;
	logic [2*HI_B+1:0]      sq_q;
	logic [2*HI_B+1:0]      v_q;
	logic [2*HI_B+1:0]      r_q;
	logic [2*HI_B:0]        bit_q;
	logic [HI_B:0]          len_q;
	logic [HI_B:0]          rem_q [3];
	logic [QB-1:0]          low_q [3];
	logic [QB-1:0]          quo_q [3];
	logic signed [NW-1:0]   nrm_q [3];
	logic                   drop_q;
	logic [KW-1:0]          cnt_q;
	logic                   ovf_q;
	logic                   rsp_valid_q;
	mvn_pkg::rsp_t          rsp_q;

	logic                   accept;
	logic                   pos_we;
	logic [IW-1:0]          pos_raddr;
	logic [3*PW-1:0]        pos_rd;
	logic                   acc_we;
	logic [IW-1:0]          acc_waddr;
	logic [IW-1:0]          acc_raddr;
	mvn_pkg::acc_t          acc_wd;
	mvn_pkg::acc_t          acc_rd;
	logic [IW-1:0]          corner_idx;
	logic signed [EW-1:0]   e1 [3];
	logic signed [EW-1:0]   e2 [3];
	logic signed [EW-1:0]   mul_a;
	logic signed [EW-1:0]   mul_b;
	logic [HI_B-1:0]        sq_op;
	logic [2*HI_B+1:0]      sqrt_t;
	logic [2*HI_B+1:0]      sqrt_r;
	logic                   sqrt_ge;
	logic                   m_zero;
	logic                   m_hi;
	logic                   m_lo;
	logic                   corner_full;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] x);
		mag = x[CW-1] ? CW'(-x) : CW'(x);
	endfunction

	function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] s,
			input logic signed [NW-1:0] d);
		logic signed [SW:0] r;
		r = $signed({s[SW-1], s}) + $signed({{(SW + 1 - NW){d[NW-1]}}, d});
		if (r[SW] != r[SW-1]) begin
			sat_add = r[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		end else begin
			sat_add = r[SW-1:0];
		end
	endfunction

	// Position store: x in the low bits
	assign pos_we = accept && (req.mode == mvn_pkg::MODE_POS);

	always_comb begin
		if (state_q == S_IDLE) begin
			pos_raddr = req.index_a;
		end else if (step_q == 5'd0) begin
			pos_raddr = req_q.index_b;
		end else begin
			pos_raddr = req_q.index_c;
		end
	end

	mvn_ram #(.WIDTH(3 * PW), .DEPTH(mvn_pkg::VERTEX_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (req.index_a),
		.wdata ({req.pos_z, req.pos_y, req.pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rd)
	);

	// Corner selected by the step counter
	always_comb begin
		case (step_q)
			5'd0:    corner_idx = req_q.index_a;
			5'd1:    corner_idx = req_q.index_b;
			default: corner_idx = req_q.index_c;
		endcase
	end

	assign acc_raddr = (state_q == S_IDLE) ? req.index_a : corner_idx;

	// Accumulator update for one corner; a full vertex only marks overflow
	assign corner_full = (acc_rd.cnt >= KW'(mvn_pkg::MAX_FACES));

	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = corner_idx;
		acc_wd    = '0;
		case (state_q)
			S_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			S_ARD: begin
				acc_we    = 1'b1;
				acc_waddr = req_q.index_a;
			end
			S_CUPD: begin
				acc_we = 1'b1;
				acc_wd = acc_rd;
				if (corner_full) begin
					acc_wd.ovf = 1'b1;
				end else begin
					acc_wd.sx  = sat_add(acc_rd.sx, nrm_q[0]);
					acc_wd.sy  = sat_add(acc_rd.sy, nrm_q[1]);
					acc_wd.sz  = sat_add(acc_rd.sz, nrm_q[2]);
					acc_wd.cnt = acc_rd.cnt + KW'(1);
				end
			end
			default: ;
		endcase
	end

	mvn_ram #(.WIDTH(AW), .DEPTH(mvn_pkg::VERTEX_COUNT)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wd),
		.raddr (acc_raddr),
		.rdata (acc_rd)
	);

	// Edge vectors by winding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (req_q.winding) begin
				e1[i] = $signed({pos_q[2][i][PW-1], pos_q[2][i]})
					- $signed({pos_q[1][i][PW-1], pos_q[1][i]});
				e2[i] = $signed({pos_q[1][i][PW-1], pos_q[1][i]})
					- $signed({pos_q[0][i][PW-1], pos_q[0][i]});
			end else begin
				e1[i] = $signed({pos_q[0][i][PW-1], pos_q[0][i]})
					- $signed({pos_q[1][i][PW-1], pos_q[1][i]});
				e2[i] = $signed({pos_q[1][i][PW-1], pos_q[1][i]})
					- $signed({pos_q[2][i][PW-1], pos_q[2][i]});
			end
		end
	end

	// Cross product operands, one product a cycle
	always_comb begin
		case (step_q)
			5'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
			5'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
			5'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
			5'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
			5'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
			default: begin mul_a = e1[1]; mul_b = e2[0]; end
		endcase
	end

	// Square operand
	always_comb begin
		case (step_q)
			5'd0:    sq_op = m_q[0][HI_B-1:0];
			5'd1:    sq_op = m_q[1][HI_B-1:0];
			default: sq_op = m_q[2][HI_B-1:0];
		endcase
	end

	// Normalizing window tests
	assign m_zero = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
	assign m_hi   = |{m_q[0][CW-1:HI_B], m_q[1][CW-1:HI_B], m_q[2][CW-1:HI_B]};
	assign m_lo   = !(|{m_q[0][CW-1:LO_B], m_q[1][CW-1:LO_B], m_q[2][CW-1:LO_B]});

	// Square root step
	assign sqrt_t  = r_q + {1'b0, bit_q};
	assign sqrt_ge = (v_q >= sqrt_t);
	assign sqrt_r  = sqrt_ge ? ((r_q >> 1) + {1'b0, bit_q}) : (r_q >> 1);

	// Control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		logic [DW-1:0]     num;
		logic [HI_B+1:0]   rem2;
		logic              ge;
		logic [QB-1:0]     qf;
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result loaded in S_OUT keeps valid high
			if (rsp_valid_q && !rsp_stall && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(mvn_pkg::VERTEX_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					step_q <= '0;
					if (accept) begin
						req_q <= req;
						if (req.mode == mvn_pkg::MODE_TRI) begin
							state_q <= S_PRD;
						end else if (req.mode == mvn_pkg::MODE_READ) begin
							state_q <= S_ARD;
						end
					end
				end
				S_PRD: begin
					pos_q[step_q[1:0]][0] <= pos_rd[PW-1:0];
					pos_q[step_q[1:0]][1] <= pos_rd[2*PW-1:PW];
					pos_q[step_q[1:0]][2] <= pos_rd[3*PW-1:2*PW];
					if (step_q == 5'd2) begin
						step_q  <= '0;
						state_q <= S_CROSS;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_CROSS: begin
					p_q <= mul_a * mul_b;
					case (step_q)
						5'd1: c_q[0] <= CW'(p_q);
						5'd2: c_q[0] <= c_q[0] - CW'(p_q);
						5'd3: c_q[1] <= CW'(p_q);
						5'd4: c_q[1] <= c_q[1] - CW'(p_q);
						5'd5: c_q[2] <= CW'(p_q);
						5'd6: c_q[2] <= c_q[2] - CW'(p_q);
						default: ;
					endcase
					if (step_q == 5'd6) begin
						state_q <= S_LOAD;
					end
					step_q <= step_q + 5'd1;
				end
				S_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]  <= mag(c_q[i]);
						ng_q[i] <= c_q[i][CW-1];
					end
					state_q <= S_NORM;
				end
				S_ARD: begin
					m_q[0]  <= mag(CW'(acc_rd.sx));
					m_q[1]  <= mag(CW'(acc_rd.sy));
					m_q[2]  <= mag(CW'(acc_rd.sz));
					ng_q[0] <= acc_rd.sx[SW-1];
					ng_q[1] <= acc_rd.sy[SW-1];
					ng_q[2] <= acc_rd.sz[SW-1];
					cnt_q   <= acc_rd.cnt;
					ovf_q   <= acc_rd.ovf;
					state_q <= S_NORM;
				end
				S_NORM: begin
					step_q <= '0;
					drop_q <= 1'b0;
					if (m_zero) begin
						for (int i = 0; i < 3; i++) begin
							nrm_q[i] <= '0;
						end
						state_q <= (req_q.mode == mvn_pkg::MODE_TRI) ? S_CRD : S_OUT;
					end else if (m_hi) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] >> 1;
						end
					end else if (m_lo) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 1;
						end
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sq_p_q <= sq_op * sq_op;
					if (step_q == 5'd1) begin
						sq_q <= (2*HI_B+2)'(sq_p_q);
					end else if (step_q == 5'd2) begin
						sq_q <= sq_q + (2*HI_B+2)'(sq_p_q);
					end
					if (step_q == 5'd3) begin
						v_q     <= sq_q + (2*HI_B+2)'(sq_p_q);
						r_q     <= '0;
						bit_q   <= {1'b1, {(2*HI_B){1'b0}}};
						step_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_SQRT: begin
					if (sqrt_ge) begin
						v_q <= v_q - sqrt_t;
					end
					r_q   <= sqrt_r;
					bit_q <= bit_q >> 2;
					if (step_q == 5'd30) begin
						len_q   <= sqrt_r[HI_B:0];
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_DIV: begin
					for (int i = 0; i < 3; i++) begin
						if (step_q == 5'd0) begin
							num = (DW'(m_q[i][HI_B-1:0]) << 14) + DW'(len_q[HI_B:1]);
							rem_q[i] <= {1'b0, num[DW-1:QB]};
							low_q[i] <= num[QB-1:0];
						end else begin
							rem2 = {rem_q[i], low_q[i][QB-1]};
							ge   = (rem2 >= {1'b0, len_q});
							rem_q[i] <= ge ? (HI_B+1)'(rem2 - {1'b0, len_q}) : rem2[HI_B:0];
							low_q[i] <= low_q[i] << 1;
							quo_q[i] <= {quo_q[i][QB-2:0], ge};
							qf = {quo_q[i][QB-2:0], ge};
							nrm_q[i] <= ng_q[i] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
						end
					end
					if (step_q == 5'(QB)) begin
						step_q  <= '0;
						state_q <= (req_q.mode == mvn_pkg::MODE_TRI) ? S_CRD : S_OUT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_CRD: begin
					state_q <= S_CUPD;
				end
				S_CUPD: begin
					if (corner_full) begin
						drop_q <= 1'b1;
					end
					if (step_q == 5'd2) begin
						state_q <= S_OUT;
					end else begin
						step_q  <= step_q + 5'd1;
						state_q <= S_CRD;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.vertex_index <= req_q.index_a;
						rsp_q.normal_x     <= nrm_q[0];
						rsp_q.normal_y     <= nrm_q[1];
						rsp_q.normal_z     <= nrm_q[2];
						if (req_q.mode == mvn_pkg::MODE_TRI) begin
							rsp_q.kind       <= mvn_pkg::KIND_FACE;
							rsp_q.face_count <= '0;
							rsp_q.overflow   <= drop_q;
						end else begin
							rsp_q.kind       <= mvn_pkg::KIND_VERTEX;
							rsp_q.face_count <= cnt_q;
							rsp_q.overflow   <= ovf_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// No beat is taken while the accumulators are being cleared
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> req_stall)
		else $error("beat accepted during clearing pass");

	// Magnitudes sit in the normalizing window before squaring
	a_norm_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ) |-> (!m_hi && !m_lo))
		else $error("squaring outside normalizing window");

	// Length feeding the dividers is at least 2^29
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (len_q[HI_B:LO_B] != 2'b00))
		else $error("divisor out of range");

	// Normal components stay within one in Q1.14
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((rsp_q.normal_x <= 16'sd16384) && (rsp_q.normal_x >= -16'sd16384)
			&& (rsp_q.normal_y <= 16'sd16384) && (rsp_q.normal_y >= -16'sd16384)
			&& (rsp_q.normal_z <= 16'sd16384) && (rsp_q.normal_z >= -16'sd16384)))
		else $error("normal component exceeds unit range");
`endif

endmodule
